@@ src/lcwf_pkg.sv @@
// ----------------------------------------------------------------------------
// Load cell weight filter package
// Shared widths, codes and handshake types of the weight filter.
// ----------------------------------------------------------------------------
package lcwf_pkg;

    localparam int WEIGHT_BITS = 24;
    localparam int VAL_W       = WEIGHT_BITS - 1;
    localparam int LP_FRAC     = 32 - WEIGHT_BITS;
    localparam int DIV_W       = 41;
    localparam int DIV_CNT_W   = $clog2(DIV_W);
    localparam int S_DATA_W    = 56;
    localparam int M_DATA_W    = 48;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [VAL_W-1:0] WMAX = {VAL_W{1'b1}};

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TARE   = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WINDOW,
        REG_GAIN_NUM,
        REG_GAIN_DEN,
        REG_STEP_LIMIT,
        REG_AZ_ENABLE,
        REG_ZERO_THRESH,
        REG_ZERO_HOLD,
        REG_WEIGHT_LIMIT
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIMIT,
        ST_MWRITE,
        ST_MOD,
        ST_CAND,
        ST_CLOAD,
        ST_SCAN,
        ST_CHECK,
        ST_AVG0,
        ST_AVG1,
        ST_AVG2,
        ST_LP,
        ST_DIV,
        ST_ADD,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [7:0]       divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ src/lcwf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lcwf_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 7
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/lcwf_div.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division of a wide dividend by an 8-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module lcwf_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  lcwf_pkg::div_req_t req,
    output lcwf_pkg::div_rsp_t rsp
);
    import lcwf_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [7:0]           rem_reg;
    logic [7:0]           dvs_reg;
    logic [8:0]           rem_sh;
    logic [8:0]           rem_diff;
    logic                 ge;

    always_comb begin
        rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
        ge       = rem_sh >= {1'b0, dvs_reg};
        rem_diff = rem_sh - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? rem_diff[7:0] : rem_sh[7:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ src/load_cell_weight_filter.sv @@
// ----------------------------------------------------------------------------
// Load cell weight filter
// Step limit, running median, first-order low-pass and auto zero of samples.
// ----------------------------------------------------------------------------
// A weight sample passes the step limit, the median and the low-pass work in
// turn. A sample is stored in the median window and the write position is
// then wrapped. With three or more held samples the rank search runs through
// the single read port of the sample store; two held samples are averaged
// instead. A low-pass update uses the bit-serial divider. A tare command
// gives no result. A new request is taken only when the previous one is
// done; a finished result waits in the output register until it is taken.
module load_cell_weight_filter #(
    parameter int MEDIAN_MAX = 7
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [lcwf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [lcwf_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // raw_weight[23:0], now_ms[55:24]
    input  logic [lcwf_pkg::S_DATA_W-1:0]       s_tdata,
    // func
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // raw_abs[22:0], filtered_weight[45:23], overweight[46], tare_request[47]
    output logic [lcwf_pkg::M_DATA_W-1:0]       m_tdata
);
    import lcwf_pkg::*;

    localparam int AW = $clog2(MEDIAN_MAX);
    localparam int CW = $clog2(MEDIAN_MAX + 1);

    state_t state_reg, state_next;

    logic [2:0]        win_cfg_reg;
    logic [7:0]        num_reg;
    logic [7:0]        den_reg;
    logic [VAL_W-1:0]  step_reg;
    logic              az_en_reg;
    logic [VAL_W-1:0]  thr_reg;
    logic [31:0]       hold_reg;
    logic [VAL_W-1:0]  wlim_reg;

    logic [VAL_W-1:0]  est_reg;
    logic              est_valid_reg;
    logic [31:0]       nzs_reg;
    logic [AW-1:0]     pos_reg;
    logic [CW-1:0]     fill_reg;
    logic signed [31:0] lp_reg;
    logic              primed_reg;

    logic [VAL_W-1:0]  raw_reg;
    logic [31:0]       now_reg;
    logic [VAL_W-1:0]  x_reg;
    logic [VAL_W-1:0]  a_reg;
    logic [VAL_W-1:0]  cand_reg;
    logic [CW-1:0]     p_reg;
    logic [CW-1:0]     n_reg;
    logic [CW-1:0]     i_reg;
    logic [CW-1:0]     j_reg;
    logic [CW-1:0]     less_reg;
    logic [CW-1:0]     eq_reg;
    logic signed [31:0] y_reg;
    logic              neg_reg;
    logic              m_tvalid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic              s_accept;
    logic              out_free;
    logic [CW-1:0]     win_eff;
    logic [CW-1:0]     fill_new;
    logic [CW-1:0]     k_mid;
    logic [CW:0]       less_eq;
    logic [WEIGHT_BITS-1:0] v_in;
    logic [WEIGHT_BITS-1:0] v_neg;
    logic [VAL_W-1:0]  rabs;
    logic signed [VAL_W+1:0] step_d;
    logic signed [VAL_W+1:0] step_s;
    logic [VAL_W-1:0]  x_lim;
    logic signed [31:0] xs;
    logic signed [32:0] lp_diff;
    logic [32:0]       lp_mag;
    logic [DIV_W-1:0]  lp_prod;
    logic signed [DIV_W:0] lp_sum;
    logic signed [31:0] lp_sat;
    logic [31:0]       y_mag;
    logic [32:0]       y_rnd;
    logic [VAL_W-1:0]  filt;
    logic [31:0]       nzs_eff;
    logic              near_zero;
    logic              tare;
    logic              overweight;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        win_eff  = (32'(win_cfg_reg) > 32'(MEDIAN_MAX)) ? CW'(MEDIAN_MAX) : CW'(win_cfg_reg);
        fill_new = (fill_reg < win_eff) ? fill_reg + 1'b1 : fill_reg;
        k_mid    = n_reg >> 1;
        less_eq  = {1'b0, less_reg} + {1'b0, eq_reg};

        v_in  = s_tdata[WEIGHT_BITS-1:0];
        v_neg = -v_in;
        if (!v_in[WEIGHT_BITS-1]) begin
            rabs = v_in[VAL_W-1:0];
        end else if (v_neg[WEIGHT_BITS-1]) begin
            rabs = WMAX;
        end else begin
            rabs = v_neg[VAL_W-1:0];
        end

        step_d = $signed({2'b00, raw_reg}) - $signed({2'b00, est_reg});
        step_s = $signed({2'b00, step_reg});
        x_lim  = raw_reg;
        if (step_reg != '0 && est_valid_reg) begin
            if (step_d > step_s) begin
                x_lim = est_reg + step_reg;
            end else if (step_d < -step_s) begin
                x_lim = est_reg - step_reg;
            end
        end

        xs      = $signed({1'b0, x_reg, {LP_FRAC{1'b0}}});
        lp_diff = 33'(xs) - 33'(lp_reg);
        lp_mag  = lp_diff[32] ? 33'(-lp_diff) : 33'(lp_diff);
        lp_prod = DIV_W'(lp_mag) * DIV_W'(num_reg) + DIV_W'(den_reg >> 1);
        lp_sum  = neg_reg ? (DIV_W+1)'(lp_reg) - $signed({1'b0, div_rsp.quotient})
                          : (DIV_W+1)'(lp_reg) + $signed({1'b0, div_rsp.quotient});
        if (lp_sum > (DIV_W+1)'(32'sh7FFFFFFF)) begin
            lp_sat = 32'sh7FFFFFFF;
        end else if (lp_sum < -(DIV_W+1)'(32'sh7FFFFFFF)) begin
            lp_sat = -32'sh7FFFFFFF;
        end else begin
            lp_sat = 32'(lp_sum);
        end

        y_mag = y_reg[31] ? 32'(-y_reg) : 32'(y_reg);
        y_rnd = {1'b0, y_mag} + 33'(1 << (LP_FRAC - 1));
        filt  = ((y_rnd >> LP_FRAC) > 33'(WMAX)) ? WMAX : VAL_W'(y_rnd >> LP_FRAC);

        near_zero  = filt < thr_reg;
        nzs_eff    = (nzs_reg == '0) ? now_reg : nzs_reg;
        tare       = az_en_reg && near_zero && ((now_reg - nzs_eff) > hold_reg);
        overweight = (wlim_reg != '0) && (filt > wlim_reg);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_tuser == FUNC_SAMPLE) begin
                    state_next = ST_LIMIT;
                end
            end
            ST_LIMIT: state_next = (win_cfg_reg <= 3'd1) ? ST_LP : ST_MWRITE;
            ST_MWRITE: state_next = ST_MOD;
            ST_MOD: begin
                if (p_reg < win_eff) begin
                    if (n_reg == CW'(1)) begin
                        state_next = ST_LP;
                    end else if (n_reg == CW'(2)) begin
                        state_next = ST_AVG0;
                    end else begin
                        state_next = ST_CAND;
                    end
                end
            end
            ST_AVG0: state_next = ST_AVG1;
            ST_AVG1: state_next = ST_AVG2;
            ST_AVG2: state_next = ST_LP;
            ST_CAND: state_next = ST_CLOAD;
            ST_CLOAD: state_next = ST_SCAN;
            ST_SCAN: state_next = (j_reg == n_reg - 1'b1) ? ST_CHECK : ST_SCAN;
            ST_CHECK: begin
                if (less_reg <= k_mid && {1'b0, k_mid} < less_eq) begin
                    state_next = ST_LP;
                end else begin
                    state_next = ST_CAND;
                end
            end
            ST_LP: begin
                if (den_reg == '0 || !est_valid_reg || !primed_reg) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: state_next = div_rsp.done ? ST_ADD : ST_DIV;
            ST_ADD: state_next = ST_FIN;
            ST_FIN: state_next = out_free ? ST_IDLE : ST_FIN;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready         = (state_reg == ST_IDLE);
        ram_we           = (state_reg == ST_MWRITE);
        ram_waddr        = pos_reg;
        ram_raddr        = '0;
        div_req.start    = (state_reg == ST_LP) && (state_next == ST_DIV);
        div_req.dividend = lp_prod;
        div_req.divisor  = den_reg;
        case (state_reg)
            ST_AVG0:  ram_raddr = '0;
            ST_AVG1:  ram_raddr = AW'(1);
            ST_CAND:  ram_raddr = i_reg[AW-1:0];
            ST_CLOAD: ram_raddr = '0;
            ST_SCAN:  ram_raddr = AW'(j_reg + 1'b1);
            default:  ram_raddr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            win_cfg_reg   <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
            step_reg      <= '0;
            az_en_reg     <= 1'b0;
            thr_reg       <= '0;
            hold_reg      <= '0;
            wlim_reg      <= '0;
            est_reg       <= '0;
            est_valid_reg <= 1'b0;
            nzs_reg       <= '0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            lp_reg        <= '0;
            primed_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_addr))
                    REG_WINDOW:       win_cfg_reg <= cfg_wr_data[2:0];
                    REG_GAIN_NUM:     num_reg     <= cfg_wr_data[7:0];
                    REG_GAIN_DEN:     den_reg     <= cfg_wr_data[7:0];
                    REG_STEP_LIMIT:   step_reg    <= cfg_wr_data[VAL_W-1:0];
                    REG_AZ_ENABLE:    az_en_reg   <= cfg_wr_data[0];
                    REG_ZERO_THRESH:  thr_reg     <= cfg_wr_data[VAL_W-1:0];
                    REG_ZERO_HOLD:    hold_reg    <= cfg_wr_data;
                    REG_WEIGHT_LIMIT: wlim_reg    <= cfg_wr_data[VAL_W-1:0];
                    default:          ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept && s_tuser == FUNC_TARE) begin
                        est_reg       <= '0;
                        est_valid_reg <= 1'b0;
                        nzs_reg       <= '0;
                        pos_reg       <= '0;
                        fill_reg      <= '0;
                        if (den_reg != '0) begin
                            lp_reg     <= '0;
                            primed_reg <= 1'b1;
                        end
                    end
                end
                ST_MWRITE: fill_reg <= fill_new;
                ST_MOD: begin
                    if (p_reg < win_eff) begin
                        pos_reg <= p_reg[AW-1:0];
                    end
                end
                ST_LP: begin
                    if (den_reg != '0 && (!est_valid_reg || !primed_reg)) begin
                        lp_reg     <= xs;
                        primed_reg <= 1'b1;
                    end
                end
                ST_ADD: lp_reg <= lp_sat;
                ST_FIN: begin
                    if (out_free) begin
                        m_tvalid_reg  <= 1'b1;
                        est_reg       <= filt;
                        est_valid_reg <= 1'b1;
                        if (az_en_reg) begin
                            nzs_reg <= near_zero ? nzs_eff : '0;
                        end
                        if (tare) begin
                            est_reg       <= '0;
                            est_valid_reg <= 1'b0;
                            nzs_reg       <= '0;
                            pos_reg       <= '0;
                            fill_reg      <= '0;
                            if (den_reg != '0) begin
                                lp_reg     <= '0;
                                primed_reg <= 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                raw_reg <= rabs;
                now_reg <= s_tdata[S_DATA_W-1:WEIGHT_BITS];
            end
            ST_LIMIT: x_reg <= x_lim;
            ST_MWRITE: begin
                p_reg <= CW'(pos_reg) + 1'b1;
                n_reg <= fill_new;
                i_reg <= '0;
            end
            ST_MOD: begin
                if (p_reg >= win_eff) begin
                    p_reg <= p_reg - win_eff;
                end
            end
            ST_AVG1: a_reg <= ram_rdata;
            ST_AVG2: x_reg <= VAL_W'(({1'b0, a_reg} + {1'b0, ram_rdata} + 1'b1) >> 1);
            ST_CLOAD: begin
                cand_reg <= ram_rdata;
                j_reg    <= '0;
                less_reg <= '0;
                eq_reg   <= '0;
            end
            ST_SCAN: begin
                if (ram_rdata < cand_reg) begin
                    less_reg <= less_reg + 1'b1;
                end
                if (ram_rdata == cand_reg) begin
                    eq_reg <= eq_reg + 1'b1;
                end
                j_reg <= j_reg + 1'b1;
            end
            ST_CHECK: begin
                x_reg <= cand_reg;
                i_reg <= i_reg + 1'b1;
            end
            ST_LP: begin
                neg_reg <= lp_diff[32];
                y_reg   <= xs;
            end
            ST_ADD: y_reg <= lp_sat;
            ST_FIN: begin
                if (out_free) begin
                    m_data_reg <= {tare, overweight, filt, raw_reg};
                end
            end
            default: ;
        endcase
    end

    lcwf_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MEDIAN_MAX)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (x_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lcwf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

endmodule

@@ src/lcwf_checker.sv @@
// ----------------------------------------------------------------------------
// Load cell weight filter checker
// Port-level checks of the weight filter, bound to its top level.
// ----------------------------------------------------------------------------
module lcwf_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lcwf_pkg::M_DATA_W-1:0] m_tdata
);
    import lcwf_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_busy_after_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == FUNC_SAMPLE |=> !s_tready)
        else $error("sample request did not make the filter busy");

    a_overweight_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[46] |-> m_tdata[45:23] != '0)
        else $error("overweight flagged with zero filtered weight");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind load_cell_weight_filter lcwf_checker u_lcwf_checker (.*);

@@ tb/sv/lcwf_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Load cell weight filter checker
// Watches the request, result and register write traffic of the weight
// filter. It keeps its own model of the filter state and compares every
// result field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module lcwf_scoreboard #(
    parameter int MEDIAN_MAX = 7
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lcwf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lcwf_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [lcwf_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [lcwf_pkg::M_DATA_W-1:0]   m_tdata,
    output int                              fail_count,
    output int                              pending_count
);
    import lcwf_pkg::*;

    typedef struct packed {
        logic             tare_request;
        logic             overweight;
        logic [VAL_W-1:0] filtered_weight;
        logic [VAL_W-1:0] raw_abs;
    } weight_result_t;

    logic [2:0]  win_r;
    logic [7:0]  num_r;
    logic [7:0]  den_r;
    logic [22:0] step_r;
    logic        az_en_r;
    logic [22:0] zthr_r;
    logic [31:0] zhold_r;
    logic [22:0] wlim_r;

    longint      est;
    bit          est_ok;
    logic [31:0] zero_since;
    longint      mstore [MEDIAN_MAX];
    int          wpos;
    int          fill;
    longint      lp_y;
    bit          lp_ok;

    weight_result_t predicted_results[$];

    function automatic longint lim_step(longint cur);
        longint l;
        l = step_r;
        if (l == 0 || !est_ok) return cur;
        if (cur - est > l) return est + l;
        if (cur - est < -l) return est - l;
        return cur;
    endfunction

    task automatic clear_filter();
        est = 0;
        est_ok = 0;
        zero_since = 0;
        wpos = 0;
        fill = 0;
        if (den_r != 0) begin
            lp_y = 0;
            lp_ok = 1;
        end
    endtask

    task automatic run_median(input longint x, output longint r);
        int     w;
        int     n;
        int     j;
        longint key;
        longint buff [MEDIAN_MAX];
        w = win_r;
        if (w <= 1) begin
            r = x;
            return;
        end
        if (w > MEDIAN_MAX) w = MEDIAN_MAX;
        if (wpos < MEDIAN_MAX) mstore[wpos] = x;
        wpos = (wpos + 1) % w;
        if (fill < w) fill++;
        n = fill;
        for (int i = 0; i < n; i++) buff[i] = mstore[i];
        for (int i = 1; i < n; i++) begin
            key = buff[i];
            j = i;
            while (j > 0 && buff[j-1] > key) begin
                buff[j] = buff[j-1];
                j--;
            end
            buff[j] = key;
        end
        if (n == 1) r = buff[0];
        else if (n == 2) r = (buff[0] + buff[1] + 1) >>> 1;
        else r = buff[n/2];
    endtask

    task automatic run_lowpass(input longint x, input bit prime, output longint r);
        longint xs;
        longint diff;
        longint mag;
        longint q;
        longint y;
        xs = x <<< LP_FRAC;
        if (den_r == 0) begin
            r = xs;
            return;
        end
        if (prime || !lp_ok) begin
            lp_y = xs;
            lp_ok = 1;
        end else begin
            diff = xs - lp_y;
            mag = (diff < 0 ? -diff : diff) * num_r;
            q = (mag + den_r / 2) / den_r;
            y = lp_y + (diff < 0 ? -q : q);
            if (y > 64'sd2147483647) y = 64'sd2147483647;
            if (y < -64'sd2147483647) y = -64'sd2147483647;
            lp_y = y;
        end
        r = lp_y;
    endtask

    task automatic predict_sample(input logic [23:0] raw, input logic [31:0] now);
        longint         rabs;
        longint         med;
        longint         y;
        longint         filt;
        weight_result_t res;
        rabs = raw[23] ? (longint'(25'h1000000) - longint'(raw)) : longint'(raw);
        if (rabs > longint'(WMAX)) rabs = WMAX;
        run_median(lim_step(rabs), med);
        run_lowpass(med, !est_ok, y);
        if (y < 0) y = -y;
        filt = (y + (1 <<< (LP_FRAC - 1))) >>> LP_FRAC;
        if (filt > longint'(WMAX)) filt = WMAX;
        est = filt;
        est_ok = 1;
        res.tare_request = 0;
        if (az_en_r) begin
            if (filt < longint'(zthr_r)) begin
                if (zero_since == 0) zero_since = now;
                if (32'(now - zero_since) > zhold_r) begin
                    res.tare_request = 1;
                    clear_filter();
                end
            end else begin
                zero_since = 0;
            end
        end
        res.raw_abs = rabs[VAL_W-1:0];
        res.filtered_weight = filt[VAL_W-1:0];
        res.overweight = (wlim_r != 0) && (filt > longint'(wlim_r));
        predicted_results.push_back(res);
    endtask

    always @(posedge aclk) begin
        weight_result_t got;
        weight_result_t exp_r;
        if (!aresetn) begin
            win_r = '0; num_r = '0; den_r = '0; step_r = '0;
            az_en_r = 0; zthr_r = '0; zhold_r = '0; wlim_r = '0;
            est = 0; est_ok = 0; zero_since = 0; wpos = 0; fill = 0;
            lp_y = 0; lp_ok = 0;
            for (int i = 0; i < MEDIAN_MAX; i++) mstore[i] = 0;
            predicted_results.delete();
            fail_count = 0;
            pending_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_addr))
                    REG_WINDOW:       win_r   = cfg_wr_data[2:0];
                    REG_GAIN_NUM:     num_r   = cfg_wr_data[7:0];
                    REG_GAIN_DEN:     den_r   = cfg_wr_data[7:0];
                    REG_STEP_LIMIT:   step_r  = cfg_wr_data[22:0];
                    REG_AZ_ENABLE:    az_en_r = cfg_wr_data[0];
                    REG_ZERO_THRESH:  zthr_r  = cfg_wr_data[22:0];
                    REG_ZERO_HOLD:    zhold_r = cfg_wr_data;
                    REG_WEIGHT_LIMIT: wlim_r  = cfg_wr_data[22:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == FUNC_TARE) clear_filter();
                else predict_sample(s_tdata[23:0], s_tdata[55:24]);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (predicted_results.size() == 0) begin
                    $error("result with no request waiting: %h", m_tdata);
                    fail_count = fail_count + 1;
                end else begin
                    exp_r = predicted_results.pop_front();
                    if (got.raw_abs !== exp_r.raw_abs) begin
                        $error("raw_abs expected %0d actual %0d",
                               exp_r.raw_abs, got.raw_abs);
                        fail_count = fail_count + 1;
                    end
                    if (got.filtered_weight !== exp_r.filtered_weight) begin
                        $error("filtered_weight expected %0d actual %0d",
                               exp_r.filtered_weight, got.filtered_weight);
                        fail_count = fail_count + 1;
                    end
                    if (got.overweight !== exp_r.overweight) begin
                        $error("overweight expected %0b actual %0b",
                               exp_r.overweight, got.overweight);
                        fail_count = fail_count + 1;
                    end
                    if (got.tare_request !== exp_r.tare_request) begin
                        $error("tare_request expected %0b actual %0b",
                               exp_r.tare_request, got.tare_request);
                        fail_count = fail_count + 1;
                    end
                end
            end
            pending_count = predicted_results.size();
        end
    end

endmodule

@@ tb/sv/tb_load_cell_weight_filter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Load cell weight filter testbench
// Drives directed and random weight and tare requests under several register
// settings, with random gaps on both channels, and reports the verdict that
// the checker's failure count gives.
// ----------------------------------------------------------------------------
module tb_load_cell_weight_filter;
    import lcwf_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    int                    fail_count;
    int                    pending_count;
    logic [31:0]           clock_ms;

    load_cell_weight_filter DUT (.*);

    lcwf_scoreboard u_checker (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #400ms;
        $display("** load_cell_weight_filter: FAILED **");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 120);
    endfunction

    initial begin
        m_tready = 0;
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 49) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(20, 150)) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) < 65);
                @(posedge aclk);
            end
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        cfg_wr_en   <= 1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
    endtask

    task automatic send(input logic func, input logic [23:0] raw, input logic [31:0] now);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= func;
        s_tdata  <= {now, raw};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    // Each new setting starts from a cleared filter so the median window
    // only ever reads entries written since the last clear.
    task automatic setup(input logic [2:0] w, input logic [7:0] n, input logic [7:0] d,
                         input logic [22:0] st, input logic az, input logic [22:0] zt,
                         input logic [31:0] zh, input logic [22:0] wl);
        write_reg(REG_WINDOW, 32'(w));
        write_reg(REG_GAIN_NUM, 32'(n));
        write_reg(REG_GAIN_DEN, 32'(d));
        write_reg(REG_STEP_LIMIT, 32'(st));
        write_reg(REG_AZ_ENABLE, 32'(az));
        write_reg(REG_ZERO_THRESH, 32'(zt));
        write_reg(REG_ZERO_HOLD, zh);
        write_reg(REG_WEIGHT_LIMIT, 32'(wl));
        cfg_wr_en <= 0;
        send(FUNC_TARE, 24'h000000, 32'd0);
    endtask

    // Near-zero weights let auto zero fire; large ones exercise saturation.
    function automatic logic [23:0] rand_weight();
        int p;
        p = $urandom_range(0, 99);
        if (p < 30) return 24'($signed($urandom_range(0, 64)) - 32);
        if (p < 40) return ($urandom_range(0, 1)) ? 24'h800000 : 24'h7FFFFF;
        if (p < 70) return 24'($urandom_range(0, 2000) + 1000);
        return 24'($urandom());
    endfunction

    task automatic random_phase(input int count);
        logic [31:0] t;
        for (int i = 0; i < count; i++) begin
            t = clock_ms;
            if ($urandom_range(0, 19) == 0) t = 0;
            else if ($urandom_range(0, 19) == 0) t = $urandom();
            send(($urandom_range(0, 24) == 0) ? FUNC_TARE : FUNC_SAMPLE,
                 rand_weight(), t);
            clock_ms = clock_ms + $urandom_range(0, 40);
        end
        drain();
    endtask

    initial begin
        aresetn     = 0;
        cfg_wr_en   = 0;
        cfg_addr    = '0;
        cfg_wr_data = '0;
        s_tvalid    = 0;
        s_tdata     = '0;
        s_tuser     = FUNC_SAMPLE;
        clock_ms    = 32'hFFFF_FF00;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        setup(3'd3, 8'd1, 8'd2, 23'd100, 1'b1, 23'd50, 32'd5, 23'd1000);
        send(FUNC_SAMPLE, 24'h800000, 32'd1);
        send(FUNC_SAMPLE, 24'h7FFFFF, 32'd2);
        send(FUNC_SAMPLE, 24'h000000, 32'd3);
        send(FUNC_SAMPLE, 24'hFFFFFF, 32'd4);
        send(FUNC_TARE,   24'h000000, 32'd5);
        send(FUNC_SAMPLE, 24'd10, 32'd0);
        send(FUNC_SAMPLE, 24'd12, 32'd3);
        send(FUNC_SAMPLE, 24'd11, 32'd9);
        send(FUNC_SAMPLE, 24'd5, 32'd20);
        drain();
        setup(3'd4, 8'd255, 8'd255, 23'h7FFFFF, 1'b0, 23'h7FFFFF, 32'hFFFFFFFF, 23'h7FFFFF);
        for (int i = 0; i < 6; i++) send(FUNC_SAMPLE, 24'(i * 3000 + 7), 32'(i));
        drain();
        setup(3'd7, 8'd0, 8'd0, 23'd0, 1'b0, 23'd0, 32'd0, 23'd0);
        for (int i = 0; i < 8; i++) send(FUNC_SAMPLE, 24'($urandom()), 32'(i));
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            setup(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  (ph % 3 == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                  (ph % 4 == 0) ? 23'd0 : 23'($urandom_range(1, 4000)),
                  1'(ph % 2), 23'($urandom_range(0, 60)), 32'($urandom_range(0, 200)),
                  (ph % 3 == 1) ? 23'd0 : 23'($urandom_range(1, 3000)));
            random_phase(145);
        end

        if (fail_count == 0) begin
            $display("** load_cell_weight_filter: PASSED **");
        end else begin
            $display("** load_cell_weight_filter: FAILED **");
        end
        $finish;
    end

endmodule
